// ----- rtl/per_source_token_bucket_policer_assert.svh -----
// Assertion macros shared by the policer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PER_SOURCE_TOKEN_BUCKET_POLICER_ASSERT_SVH
`define PER_SOURCE_TOKEN_BUCKET_POLICER_ASSERT_SVH

// Same-cycle implication, switched off while the disable term is high.
`define PBP_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("policer assertion failed");

// Next-cycle implication, switched off while the disable term is high.
`define PBP_ASSERT_NXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("policer assertion failed");

`endif

// ----- rtl/pbp_pkg.sv -----
// Types and constants of the per-source token bucket policer.
// No dependencies; imported by every module of the block but pbp_ram.
`default_nettype none

package pbp_pkg;

  localparam int unsigned TOK_W     = 36;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MS_PER_S  = 1000;

  typedef enum logic [1:0] {
    REQ_PACKET = 2'd0,
    REQ_SET    = 2'd1,
    REQ_PURGE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic [2:0] STAT_PASS      = 3'd0;
  localparam logic [2:0] STAT_DROP      = 3'd1;
  localparam logic [2:0] STAT_UNLIMITED = 3'd2;
  localparam logic [2:0] STAT_UNTRACKED = 3'd3;
  localparam logic [2:0] STAT_RATE_SET  = 3'd4;
  localparam logic [2:0] STAT_RATE_FULL = 3'd5;
  localparam logic [2:0] STAT_PURGED    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_FACTOR = 2'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] source_ip;
    logic [15:0] packet_bytes;
    logic [31:0] rate_value;
    logic [15:0] idle_seconds;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic             allowed;
    logic [2:0]       status;
    logic [TOK_W-1:0] tokens_left;
    logic [8:0]       purged_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] global_rate;
    logic [4:0]  burst_factor;
  } cfg_t;

  typedef struct packed {
    logic [31:0]      source;
    logic [TOK_W-1:0] tokens;
    logic [31:0]      stamp;
  } bucket_ent_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CAP,
    BK_SCAN,
    BK_MATCH,
    BK_MUL,
    BK_DIV,
    BK_FRAC,
    BK_ADD,
    BK_SUM,
    BK_CHECK,
    BK_PURGE_SCAN,
    BK_PURGE_CHK,
    BK_RESULT
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/pbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pbp_front.sv -----
// Front end: accepts requests, discards undefined request types and queues the rest.
// Depends on pbp_pkg.
`default_nettype none

module pbp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pbp_pkg::in_item_t in_data,
  output logic                  head_valid,
  output pbp_pkg::in_item_t     head_data,
  input  wire logic             head_pop
);
  import pbp_pkg::*;

  in_item_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  // A transaction of the undefined type is accepted but never queued.
  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready && (in_data.req_type != REQ_NONE);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = q_r[rd_ptr_r];
  assign pop        = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pbp_back.sv -----
// Back end: override table, bucket scan, refill divider, purge walk and result register.
// Depends on pbp_pkg and pbp_ram.
`default_nettype none

module pbp_back #(
  parameter int unsigned BUCKET_ENTRIES   = 256,
  parameter int unsigned OVERRIDE_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbp_pkg::cfg_t     cfg,
  input  wire logic              head_valid,
  input  wire pbp_pkg::in_item_t head_data,
  output logic                   head_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pbp_pkg::out_item_t     out_data
);
  import pbp_pkg::*;

  localparam int unsigned AW = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned OW = (OVERRIDE_ENTRIES > 1) ? $clog2(OVERRIDE_ENTRIES) : 1;
  localparam int unsigned BW = $bits(bucket_ent_t);

  // Reciprocals of 1000: exact quotients for 32-bit and 20-bit dividends.
  localparam logic [28:0] RECIP_32    = 29'd274877907;
  localparam int unsigned RECIP_32_SH = 38;
  localparam logic [20:0] RECIP_20    = 21'd1073742;
  localparam int unsigned RECIP_20_SH = 30;

  back_state_e        state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [31:0]        rate_r, rate_nxt;
  logic [TOK_W-1:0]   cap_r, cap_nxt;
  logic [TOK_W-1:0]   tok_r, tok_nxt;
  logic [31:0]        stamp_r, stamp_nxt;
  logic [31:0]        el_r, el_nxt;
  logic [31:0]        limit_r, limit_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [22:0]        qel_r, qel_nxt;
  logic [22:0]        qrt_r, qrt_nxt;
  logic [9:0]         rel_r, rel_nxt;
  logic [9:0]         rrt_r, rrt_nxt;
  logic [19:0]        fx_r, fx_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic               free_vld_r, free_vld_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic               alloc_r, alloc_nxt;
  logic [8:0]         pcnt_r, pcnt_nxt;
  out_item_t          res_r, res_nxt;
  logic [BUCKET_ENTRIES-1:0] used_r, used_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [OVERRIDE_ENTRIES-1:0] ovr_used_r, ovr_used_nxt;
  logic [31:0]        ovr_src_r  [OVERRIDE_ENTRIES];
  logic [31:0]        ovr_rate_r [OVERRIDE_ENTRIES];
  logic               ovr_we;
  logic [OW-1:0]      ovr_widx;

  logic               hit;
  logic [OW-1:0]      hit_idx;
  logic               ofree;
  logic [OW-1:0]      ofree_idx;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  bucket_ent_t        ram_wdata;
  logic               ram_re;
  bucket_ent_t        ram_rdata;
  logic [BW-1:0]      ram_rbits;

  logic [36:0]        cap_full;
  logic [60:0]        qel_full;
  logic [60:0]        qrt_full;
  logic [32:0]        rel_diff;
  logic [32:0]        rrt_diff;
  logic [40:0]        frac_full;
  logic [64:0]        sum;
  logic [TOK_W-1:0]   len_ext;
  logic [31:0]        age;
  logic               scan_end;

  assign ram_rdata = bucket_ent_t'(ram_rbits);

  pbp_ram #(
    .WIDTH (BW),
    .DEPTH (BUCKET_ENTRIES)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rbits)
  );

  // Override table search: first entry that matches the head source and lowest free entry.
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    ofree     = 1'b0;
    ofree_idx = '0;
    for (int i = 0; i < OVERRIDE_ENTRIES; i++) begin
      if (ovr_used_r[i]) begin
        if (!hit && ovr_src_r[i] == head_data.source_ip) begin
          hit     = 1'b1;
          hit_idx = OW'(i);
        end
      end else if (!ofree) begin
        ofree     = 1'b1;
        ofree_idx = OW'(i);
      end
    end
  end

  // Datapath terms used by the sequencer.
  assign cap_full  = 37'(rate_r) * 37'(cfg.burst_factor);
  assign qel_full  = 61'(el_r) * 61'(RECIP_32);
  assign qrt_full  = 61'(rate_r) * 61'(RECIP_32);
  assign rel_diff  = 33'(el_r) - 33'(qel_r) * 33'(MS_PER_S);
  assign rrt_diff  = 33'(rate_r) - 33'(qrt_r) * 33'(MS_PER_S);
  assign frac_full = 41'(fx_r) * 41'(RECIP_20);
  assign sum       = 65'(tok_r) + 65'(prod_r);
  assign len_ext   = TOK_W'(item_r.packet_bytes);
  assign age       = item_r.now_ms - ram_rdata.stamp;
  assign scan_end  = (idx_r == CW'(BUCKET_ENTRIES));

  // Sequencer: next state, datapath registers and result.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    rate_nxt      = rate_r;
    cap_nxt       = cap_r;
    tok_nxt       = tok_r;
    stamp_nxt     = stamp_r;
    el_nxt        = el_r;
    limit_nxt     = limit_r;
    prod_nxt      = prod_r;
    qel_nxt       = qel_r;
    qrt_nxt       = qrt_r;
    rel_nxt       = rel_r;
    rrt_nxt       = rrt_r;
    fx_nxt        = fx_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    alloc_nxt     = alloc_r;
    pcnt_nxt      = pcnt_r;
    res_nxt       = res_r;
    used_nxt      = used_r;
    ovr_used_nxt  = ovr_used_r;
    ovr_we        = 1'b0;
    ovr_widx      = hit_idx;
    head_pop      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = '{source: item_r.source_ip, tokens: tok_r, stamp: stamp_r};
    ram_re        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          item_nxt = head_data;
          idx_nxt  = '0;
          res_nxt  = '0;
          unique case (req_e'(head_data.req_type))
            REQ_PACKET: begin
              rate_nxt  = hit ? ovr_rate_r[hit_idx] : cfg.global_rate;
              state_nxt = BK_CAP;
            end
            REQ_SET: begin
              if (hit || ofree) begin
                ovr_we   = 1'b1;
                ovr_widx = hit ? hit_idx : ofree_idx;
                ovr_used_nxt[ovr_widx] = 1'b1;
                res_nxt.status = STAT_RATE_SET;
              end else begin
                res_nxt.status = STAT_RATE_FULL;
              end
              state_nxt = BK_RESULT;
            end
            REQ_PURGE: begin
              limit_nxt = 32'(32'(head_data.idle_seconds) * 32'(MS_PER_S));
              pcnt_nxt  = '0;
              state_nxt = BK_PURGE_SCAN;
            end
            REQ_NONE: begin
              state_nxt = BK_IDLE;
            end
            default: state_nxt = BK_IDLE;
          endcase
        end
      end

      BK_CAP: begin
        if (rate_r == 32'd0) begin
          res_nxt.allowed = 1'b1;
          res_nxt.status  = STAT_UNLIMITED;
          state_nxt       = BK_RESULT;
        end else begin
          cap_nxt      = cap_full[36] ? '1 : cap_full[TOK_W-1:0];
          free_vld_nxt = 1'b0;
          alloc_nxt    = 1'b0;
          state_nxt    = BK_SCAN;
        end
      end

      // One free bucket a cycle; a used bucket is read and compared in the next cycle.
      BK_SCAN: begin
        if (scan_end) begin
          if (free_vld_r) begin
            alloc_nxt = 1'b1;
            slot_nxt  = free_idx_r;
            tok_nxt   = cap_r;
            stamp_nxt = item_r.now_ms;
            state_nxt = BK_CHECK;
          end else begin
            res_nxt.allowed = 1'b1;
            res_nxt.status  = STAT_UNTRACKED;
            state_nxt       = BK_RESULT;
          end
        end else if (used_r[idx_r[AW-1:0]]) begin
          ram_re    = 1'b1;
          state_nxt = BK_MATCH;
        end else begin
          if (!free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = idx_r[AW-1:0];
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      BK_MATCH: begin
        if (ram_rdata.source == item_r.source_ip) begin
          slot_nxt  = idx_r[AW-1:0];
          tok_nxt   = ram_rdata.tokens;
          stamp_nxt = ram_rdata.stamp;
          el_nxt    = age;
          state_nxt = (age == 32'd0) ? BK_CHECK : BK_MUL;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = BK_SCAN;
        end
      end

      // Refill rate * el / 1000 is split as rate * (el / 1000) plus
      // (rate / 1000) * (el % 1000) plus (rate % 1000) * (el % 1000) / 1000.
      BK_MUL: begin
        qel_nxt   = qel_full[RECIP_32_SH +: 23];
        qrt_nxt   = qrt_full[RECIP_32_SH +: 23];
        state_nxt = BK_DIV;
      end

      // Remainders of the elapsed time and the rate by 1000.
      BK_DIV: begin
        rel_nxt   = rel_diff[9:0];
        rrt_nxt   = rrt_diff[9:0];
        state_nxt = BK_FRAC;
      end

      BK_FRAC: begin
        prod_nxt  = 64'(rate_r) * 64'(qel_r) + 64'(qrt_r) * 64'(rel_r);
        fx_nxt    = 20'(rrt_r) * 20'(rel_r);
        state_nxt = BK_ADD;
      end

      BK_ADD: begin
        prod_nxt  = prod_r + 64'(frac_full[RECIP_20_SH +: 11]);
        state_nxt = BK_SUM;
      end

      BK_SUM: begin
        tok_nxt   = (sum < 65'(cap_r)) ? sum[TOK_W-1:0] : cap_r;
        stamp_nxt = item_r.now_ms;
        state_nxt = BK_CHECK;
      end

      BK_CHECK: begin
        ram_we = 1'b1;
        if (alloc_r) begin
          used_nxt[slot_r] = 1'b1;
        end
        if (tok_r >= len_ext) begin
          ram_wdata.tokens    = tok_r - len_ext;
          res_nxt.allowed     = 1'b1;
          res_nxt.status      = STAT_PASS;
          res_nxt.tokens_left = tok_r - len_ext;
        end else begin
          res_nxt.status      = STAT_DROP;
          res_nxt.tokens_left = tok_r;
        end
        state_nxt = BK_RESULT;
      end

      BK_PURGE_SCAN: begin
        if (scan_end) begin
          res_nxt.status       = STAT_PURGED;
          res_nxt.purged_count = pcnt_r;
          state_nxt            = BK_RESULT;
        end else if (used_r[idx_r[AW-1:0]]) begin
          ram_re    = 1'b1;
          state_nxt = BK_PURGE_CHK;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      BK_PURGE_CHK: begin
        if (age > limit_r) begin
          used_nxt[idx_r[AW-1:0]] = 1'b0;
          if (pcnt_r != 9'h1FF) begin
            pcnt_nxt = pcnt_r + 9'd1;
          end
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = BK_PURGE_SCAN;
      end

      BK_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = BK_IDLE;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      used_r      <= '0;
      ovr_used_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovr_used_r  <= ovr_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rate_r     <= rate_nxt;
    cap_r      <= cap_nxt;
    tok_r      <= tok_nxt;
    stamp_r    <= stamp_nxt;
    el_r       <= el_nxt;
    limit_r    <= limit_nxt;
    prod_r     <= prod_nxt;
    qel_r      <= qel_nxt;
    qrt_r      <= qrt_nxt;
    rel_r      <= rel_nxt;
    rrt_r      <= rrt_nxt;
    fx_r       <= fx_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    free_vld_r <= free_vld_nxt;
    free_idx_r <= free_idx_nxt;
    alloc_r    <= alloc_nxt;
    pcnt_r     <= pcnt_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // Override table storage.
  always_ff @(posedge clk) begin
    if (ovr_we) begin
      ovr_src_r[ovr_widx]  <= item_nxt.source_ip;
      ovr_rate_r[ovr_widx] <= item_nxt.rate_value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/per_source_token_bucket_policer.sv -----
// Channel      Direction  Payload                      Handshake
// in_          input      pbp_pkg::in_item_t           in_valid / in_ready
// out_         output     pbp_pkg::out_item_t          out_valid / out_ready
// cfg_         input      cfg_index, cfg_data          cfg_valid / cfg_ready
//
// A packet scans the buckets up to its match; a used bucket costs a RAM read and a compare
// (single RAM read port), and the reciprocal refill runs only when time has passed. A new
// source scans the whole table and takes its lowest free bucket; with no free bucket the
// packet passes untracked. An unlimited packet skips the scan; a purge walks the whole table.
// Reset is synchronous and clears all valid bits at once; there is no clearing pass. A
// stalled output holds its result while the front queue keeps taking up to two requests.
// Top level of the per-source token bucket policer; depends on pbp_pkg,
// pbp_front, pbp_back and pbp_ram.
`default_nettype none

module per_source_token_bucket_policer #(
  parameter int unsigned BUCKET_ENTRIES   = 256,
  parameter int unsigned OVERRIDE_ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire pbp_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output pbp_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import pbp_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     head_valid;
  in_item_t head_data;
  logic     head_pop;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_GLOBAL_RATE) begin
        cfg_nxt.global_rate = cfg_data;
      end else if (cfg_index == CFG_BURST_FACTOR) begin
        cfg_nxt.burst_factor = cfg_data[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{global_rate: 32'd0, burst_factor: 5'd2};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_pop   (head_pop)
  );

  pbp_back #(
    .BUCKET_ENTRIES   (BUCKET_ENTRIES),
    .OVERRIDE_ENTRIES (OVERRIDE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/pbp_checker.sv -----
// Port-level checker for the policer, bound to the top level.
// Depends on pbp_pkg and per_source_token_bucket_policer_assert.svh.
`default_nettype none

`include "per_source_token_bucket_policer_assert.svh"

module pbp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire pbp_pkg::out_item_t out_data
);
  import pbp_pkg::*;

  // A result waiting for the consumer keeps its transaction.
  `PBP_ASSERT_NXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // Only passed, unlimited and untracked packets are allowed.
  `PBP_ASSERT_IMP(a_allowed_status, clk, !rst_n, out_valid && out_data.allowed, out_data.status == STAT_PASS || out_data.status == STAT_UNLIMITED || out_data.status == STAT_UNTRACKED)

  // Only a purge reports a count.
  `PBP_ASSERT_IMP(a_purge_count, clk, !rst_n, out_valid && out_data.status != STAT_PURGED, out_data.purged_count == 9'd0)

  // Reset leaves no result pending.
  `PBP_ASSERT_NXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid)

endmodule

bind per_source_token_bucket_policer pbp_checker u_pbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
